### hdl/ps2_mouse_packet_tracker_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PS2MT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2mt: same-cycle check failed");

// next-cycle implication
`define PS2MT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2mt: next-cycle check failed");

`else

`define PS2MT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PS2MT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, constants and payload types.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

   localparam int COORD_BITS     = 12;
   localparam int OUT_COORD_BITS = 12;
   localparam int CFG_BITS       = 13;
   localparam int CSR_IDX_BITS   = 1;
   localparam int COORD_SPAN     = 1 << COORD_BITS;
   localparam int COORD_MAX      = COORD_SPAN - 1;

   localparam int HOME_X_INT = (400 > COORD_MAX) ? COORD_MAX : 400;
   localparam int HOME_Y_INT = (300 > COORD_MAX) ? COORD_MAX : 300;
   localparam logic [COORD_BITS-1:0] HOME_X = COORD_BITS'(HOME_X_INT);
   localparam logic [COORD_BITS-1:0] HOME_Y = COORD_BITS'(HOME_Y_INT);

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(800);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(600);

   // status and header bit positions
   localparam int STATUS_READY_BIT = 0;
   localparam int STATUS_AUX_BIT   = 5;
   localparam int HEADER_SYNC_BIT  = 3;
   localparam int BTN_LEFT_BIT     = 0;
   localparam int BTN_RIGHT_BIT    = 1;
   localparam int BTN_MIDDLE_BIT   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DX     = 2'd1,
      PHASE_DY     = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [OUT_COORD_BITS-1:0] pointer_x;
      logic [OUT_COORD_BITS-1:0] pointer_y;
      logic                      left_pressed;
      logic                      right_pressed;
      logic                      middle_pressed;
      logic                      packet_done;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

### hdl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle; the result register and the input register
// advance together whenever the result slot is free or being taken.
// Reset (synchronous, active high) empties both stages, homes the pointer,
// releases the buttons, restarts framing and restores an 800 x 600 screen.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_macros.svh"

module ps2_mouse_packet_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ps2mt_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ps2mt_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [ps2mt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ps2mt_pkg::CFG_BITS-1:0]      csr_wdata
);

   logic                      stage_valid;
   ps2mt_pkg::req_type        stage_data;
   ps2mt_pkg::stage_ctl_type  ctl;
   ps2mt_pkg::rsp_type        result;
   logic                      rsp_vld_ff;
   logic                      rsp_vld_in;
   ps2mt_pkg::rsp_type        rsp_ff;

   // move the held item into the result slot when that slot frees up
   assign ctl.valid   = stage_valid;
   assign ctl.advance = stage_valid && (!rsp_vld_ff || rsp_ready);

   ps2mt_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (ctl.advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   ps2mt_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .item      (stage_data),
      .result    (result)
   );

   assign rsp_vld_in = ctl.advance || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `PS2MT_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_valid && req_ready, stage_valid)
   `PS2MT_ASSERT_NEXT(a_stalled_stage_holds, clock, reset, stage_valid && !ctl.advance, stage_valid)
   `PS2MT_ASSERT_NEXT(a_advance_fills_result, clock, reset, ctl.advance, rsp_valid)
   `PS2MT_ASSERT_IMPL(a_no_advance_when_full, clock, reset, rsp_valid && !rsp_ready, !ctl.advance)

endmodule

### hdl/ps2mt_in_reg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker input register
// Holds one accepted item until the tracker consumes it.
// ----------------------------------------------------------------------------
module ps2mt_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ps2mt_pkg::req_type req_data,
   input  logic              advance,
   output logic              stage_valid,
   output ps2mt_pkg::req_type stage_data
);

   logic               vld_ff;
   logic               vld_in;
   ps2mt_pkg::req_type data_ff;
   logic               load;

   // take a new item whenever the held one leaves or the register is empty
   assign req_ready = !vld_ff || advance;
   assign load      = req_valid && req_ready;
   assign vld_in    = load || (vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign stage_valid = vld_ff;
   assign stage_data  = data_ff;

endmodule

### hdl/ps2mt_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker core
// Frames packet bytes, moves and clamps the pointer, holds screen size.
// ----------------------------------------------------------------------------
module ps2mt_tracker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [ps2mt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ps2mt_pkg::CFG_BITS-1:0]         csr_wdata,
   input  ps2mt_pkg::stage_ctl_type               ctl,
   input  ps2mt_pkg::req_type                     item,
   output ps2mt_pkg::rsp_type                     result
);

   localparam int CB       = ps2mt_pkg::COORD_BITS;
   localparam int SUM_BITS = CB + 2;
   localparam int LIM_BITS = (CB + 1 > ps2mt_pkg::CFG_BITS) ? CB + 1 : ps2mt_pkg::CFG_BITS;

   logic [ps2mt_pkg::CFG_BITS-1:0] width_ff;
   logic [ps2mt_pkg::CFG_BITS-1:0] height_ff;

   ps2mt_pkg::phase_type phase_ff, phase_in;
   logic [2:0]           header_ff, header_in;
   logic [7:0]           dx_ff, dx_in;
   logic [CB-1:0]        pos_x_ff, pos_x_in;
   logic [CB-1:0]        pos_y_ff, pos_y_in;
   logic [2:0]           btn_ff, btn_in;
   logic                 done;

   logic                      used;
   logic signed [SUM_BITS-1:0] next_x;
   logic signed [SUM_BITS-1:0] next_y;

   function automatic logic [CB-1:0] clamp_axis(
      input logic signed [SUM_BITS-1:0]      v,
      input logic [ps2mt_pkg::CFG_BITS-1:0]  size
   );
      logic [LIM_BITS-1:0] size_w;
      logic [LIM_BITS-1:0] span;
      logic [CB:0]         lim;
      logic [CB-1:0]       res;
      size_w = LIM_BITS'(size);
      span   = LIM_BITS'(ps2mt_pkg::COORD_SPAN);
      if (size_w == '0) begin
         lim = (CB + 1)'(1);
      end else if (size_w > span) begin
         lim = span[CB:0];
      end else begin
         lim = size_w[CB:0];
      end
      if (v[SUM_BITS-1]) begin
         res = '0;
      end else if (v[CB:0] >= lim) begin
         res = CB'(lim - (CB + 1)'(1));
      end else begin
         res = v[CB-1:0];
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2mt_pkg::WIDTH_RESET;
         height_ff <= ps2mt_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ps2mt_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            ps2mt_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign used = ctl.valid && item.status_byte[ps2mt_pkg::STATUS_READY_BIT]
                 && item.status_byte[ps2mt_pkg::STATUS_AUX_BIT];

   // sign-extend both deltas; Y grows downward so its delta is subtracted
   assign next_x = signed'({2'b00, pos_x_ff})
                 + signed'({{(SUM_BITS-8){dx_ff[7]}}, dx_ff});
   assign next_y = signed'({2'b00, pos_y_ff})
                 - signed'({{(SUM_BITS-8){item.data_byte[7]}}, item.data_byte});

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (used) begin
         case (phase_ff)
            ps2mt_pkg::PHASE_HEADER: begin
               if (item.data_byte[ps2mt_pkg::HEADER_SYNC_BIT]) begin
                  phase_in = ps2mt_pkg::PHASE_DX;
               end
            end
            ps2mt_pkg::PHASE_DX: phase_in = ps2mt_pkg::PHASE_DY;
            ps2mt_pkg::PHASE_DY: phase_in = ps2mt_pkg::PHASE_HEADER;
            default:             phase_in = phase_ff;
         endcase
      end
   end

   // datapath updates per phase
   always_comb begin
      header_in = header_ff;
      dx_in     = dx_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      btn_in    = btn_ff;
      done      = 1'b0;
      if (used) begin
         case (phase_ff)
            ps2mt_pkg::PHASE_HEADER: header_in = item.data_byte[2:0];
            ps2mt_pkg::PHASE_DX:     dx_in     = item.data_byte;
            ps2mt_pkg::PHASE_DY: begin
               btn_in   = header_ff;
               pos_x_in = clamp_axis(next_x, width_ff);
               pos_y_in = clamp_axis(next_y, height_ff);
               done     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ps2mt_pkg::PHASE_HEADER;
         header_ff <= 3'b000;
         dx_ff     <= 8'h00;
         pos_x_ff  <= ps2mt_pkg::HOME_X;
         pos_y_ff  <= ps2mt_pkg::HOME_Y;
         btn_ff    <= 3'b000;
      end else if (ctl.advance) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         dx_ff     <= dx_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         btn_ff    <= btn_in;
      end
   end

   assign result.pointer_x      = ps2mt_pkg::OUT_COORD_BITS'(pos_x_in);
   assign result.pointer_y      = ps2mt_pkg::OUT_COORD_BITS'(pos_y_in);
   assign result.left_pressed   = btn_in[ps2mt_pkg::BTN_LEFT_BIT];
   assign result.right_pressed  = btn_in[ps2mt_pkg::BTN_RIGHT_BIT];
   assign result.middle_pressed = btn_in[ps2mt_pkg::BTN_MIDDLE_BIT];
   assign result.packet_done    = done;

endmodule
